// ===== design/bti_pkg.sv =====
// shared constants and codes for the breakpoint table interpolator
package bti_pkg;

    // default table depth and fraction bits
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;

    // fixed field widths
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 32;
    localparam int LEN_W   = 7;

    // function codes of an input transaction
    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FORWARD = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_INVERSE = 2'd2;

    // reciprocal of ten for the inverse step size, exact for any 32-bit span
    localparam logic [DATA_W-1:0] STEP_RECIP = 32'hCCCCCCCD;
    localparam int                STEP_SHIFT = 35;

endpackage

// ===== design/breakpoint_table_interpolator_top.sv =====
// breakpoint table with piecewise linear forward lookup and inverse search
// The block handles one transaction at a time and holds o_stall high while it works. A forward
// lookup reads the table entry by entry over one shared memory read port, then runs a shared
// restoring divider and a multiply and round step. An inverse lookup walks every segment; a
// bracketing segment uses a reciprocal multiplication for its step size and then one forward
// lookup per sample, up to eleven samples. The result sits in an output register until taken,
// so the next transaction can be accepted meanwhile. Table entries have no reset.
module breakpoint_table_interpolator_top #(
    parameter int TABLE_DEPTH = bti_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = bti_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [bti_pkg::LEN_W-1:0]           i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [bti_pkg::FUNC_W-1:0]          i_func,
    input  logic [bti_pkg::INDEX_W-1:0]         i_entry_index,
    input  logic signed [bti_pkg::DATA_W-1:0]   i_entry_x,
    input  logic signed [bti_pkg::DATA_W-1:0]   i_entry_y,
    input  logic signed [bti_pkg::DATA_W-1:0]   i_query_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [bti_pkg::DATA_W-1:0]   o_result_value
);
    import bti_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int PW    = 34 + FRAC_BITS;
    localparam int TENTH = ((1 << FRAC_BITS) + 5) / 10;
    localparam logic signed [PW-1:0] HALF_Q = PW'(1) <<< (FRAC_BITS - 1);
    localparam logic [DATA_W-1:0] TENTH_Q = DATA_W'(TENTH);
    localparam logic [5:0] FRAC_CNT = 6'(FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_C0, S_CN, S_F0, S_FSCAN, S_DIV, S_FMUL, S_FADD,
        S_FRET, S_SEG, S_BR, S_HDIV, S_HSET, S_NXT, S_OUT
    } t_state;

    // table storage
    logic signed [DATA_W-1:0] x_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] y_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] r_xrd, r_yrd;
    logic [AW-1:0]            r_addr;
    logic                     r_wait;

    t_state                   r_state;
    logic [LEN_W-1:0]         r_used_len;
    logic [AW:0]              w_len;
    logic [AW-1:0]            w_last;
    logic                     w_accept, w_wr;

    // query context
    logic signed [DATA_W-1:0] r_v;
    logic                     r_inv;
    logic signed [DATA_W-1:0] r_x0, r_y0, r_xn, r_yn;
    logic signed [DATA_W-1:0] r_res, r_ovalue;
    logic                     r_ovalid;

    // forward lookup
    logic signed [DATA_W-1:0] r_fv, r_fxl, r_fyl, r_fyr, r_fres;
    logic [AW-1:0]            r_fi;
    logic signed [PW-1:0]     r_prod;

    // shared divider
    logic [DATA_W-1:0]        r_rem, r_dq, r_dd, r_quot;
    logic [5:0]               r_cnt;
    logic [DATA_W:0]          w_dt;
    logic                     w_dge;

    // inverse search
    logic signed [DATA_W-1:0] r_sxl, r_sxr, r_syl, r_syr;
    logic [AW-1:0]            r_si;
    logic [DATA_W-1:0]        r_h;
    logic signed [DATA_W+1:0] r_s;
    logic signed [DATA_W-1:0] r_best_x;
    logic [DATA_W:0]          r_best_err;
    logic                     r_found;

    // combinational helpers
    logic signed [DATA_W:0]   w_span, w_num, w_diff, w_err_d;
    logic [DATA_W:0]          w_err;
    logic signed [DATA_W+1:0] w_snext;
    logic signed [PW-1:0]     w_round;
    logic signed [DATA_W+1:0] w_fsum;
    logic                     w_brk;
    logic signed [DATA_W:0]   w_dy;
    logic signed [FRAC_BITS:0] w_wq;
    logic signed [PW-1:0]     w_prod;
    logic [2*DATA_W-1:0]      w_recip;

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_result_value = r_ovalue;
    assign w_accept       = i_valid && !o_stall;
    assign w_wr           = w_accept && (i_func == FUNC_WRITE)
                            && (32'(i_entry_index) < TABLE_DEPTH);

    // effective length saturates at the depth
    always_comb begin
        if (32'(r_used_len) > TABLE_DEPTH) begin
            w_len = (AW+1)'(TABLE_DEPTH);
        end else begin
            w_len = (AW+1)'(r_used_len);
        end
        w_last = AW'(w_len - 1'b1);
    end

    // datapath helpers
    always_comb begin
        w_span  = {r_xrd[DATA_W-1], r_xrd} - {r_fxl[DATA_W-1], r_fxl};
        w_num   = {r_fv[DATA_W-1], r_fv} - {r_fxl[DATA_W-1], r_fxl};
        w_diff  = {r_sxr[DATA_W-1], r_sxr} - {r_sxl[DATA_W-1], r_sxl};
        w_err_d = {r_fres[DATA_W-1], r_fres} - {r_v[DATA_W-1], r_v};
        w_err   = w_err_d[DATA_W] ? 33'(-w_err_d) : 33'(w_err_d);
        w_snext = r_s + $signed({2'b00, r_h});
        w_round = (r_prod + HALF_Q) >>> FRAC_BITS;
        w_fsum  = {{2{r_fyl[DATA_W-1]}}, r_fyl} + w_round[DATA_W+1:0];
        w_dt    = {r_rem, r_dq[DATA_W-1]};
        w_dge   = (w_dt >= {1'b0, r_dd});
        w_brk   = ((r_v >= r_syl) && (r_v <= r_syr)) || ((r_v <= r_syl) && (r_v >= r_syr));
        w_dy    = {r_fyr[DATA_W-1], r_fyr} - {r_fyl[DATA_W-1], r_fyl};
        w_wq    = $signed({1'b0, r_quot[FRAC_BITS-1:0]});
        w_prod  = w_dy * w_wq;
        w_recip = r_dq * STEP_RECIP;
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            x_mem[AW'(i_entry_index)] <= i_entry_x;
            y_mem[AW'(i_entry_index)] <= i_entry_y;
        end
        r_xrd <= x_mem[r_addr];
        r_yrd <= y_mem[r_addr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used_len <= '0;
        end else if (i_cfg_wr_en) begin
            r_used_len <= i_cfg_wr_data;
        end
    end

    // sequencer with registered output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
            r_found  <= 1'b0;
            r_cnt    <= '0;
            r_addr   <= '0;
        end else begin
            // output state reloads the register itself
            if (r_ovalid && !i_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            if (r_wait) begin
                r_wait <= 1'b0;
            end else begin
                case (r_state)
                    S_IDLE: begin
                        if (w_accept && (i_func == FUNC_FORWARD || i_func == FUNC_INVERSE)) begin
                            r_v   <= i_query_value;
                            r_inv <= (i_func == FUNC_INVERSE);
                            if (w_len == '0) begin
                                r_res   <= '0;
                                r_state <= S_OUT;
                            end else begin
                                r_addr  <= '0;
                                r_wait  <= 1'b1;
                                r_state <= S_C0;
                            end
                        end
                    end
                    S_C0: begin
                        r_x0    <= r_xrd;
                        r_y0    <= r_yrd;
                        r_addr  <= w_last;
                        r_wait  <= 1'b1;
                        r_state <= S_CN;
                    end
                    S_CN: begin
                        r_xn <= r_xrd;
                        r_yn <= r_yrd;
                        if (!r_inv) begin
                            r_fv    <= r_v;
                            r_state <= S_F0;
                        end else if (w_len == (AW+1)'(1)) begin
                            r_res   <= r_x0;
                            r_state <= S_OUT;
                        end else begin
                            r_sxr      <= r_x0;
                            r_syr      <= r_y0;
                            r_si       <= AW'(1);
                            r_found    <= 1'b0;
                            r_best_x   <= '0;
                            r_best_err <= '0;
                            r_addr     <= AW'(1);
                            r_wait     <= 1'b1;
                            r_state    <= S_SEG;
                        end
                    end
                    // forward lookup: end cases, then scan for the segment
                    S_F0: begin
                        if (r_fv < r_x0) begin
                            r_fres  <= r_y0;
                            r_state <= S_FRET;
                        end else if (r_fv >= r_xn) begin
                            r_fres  <= r_yn;
                            r_state <= S_FRET;
                        end else begin
                            r_fxl   <= r_x0;
                            r_fyl   <= r_y0;
                            r_fi    <= AW'(1);
                            r_addr  <= AW'(1);
                            r_wait  <= 1'b1;
                            r_state <= S_FSCAN;
                        end
                    end
                    S_FSCAN: begin
                        if (r_fv < r_xrd) begin
                            if (w_span <= 0) begin
                                r_fres  <= r_fyl;
                                r_state <= S_FRET;
                            end else begin
                                r_fyr   <= r_yrd;
                                r_dd    <= w_span[DATA_W-1:0];
                                r_rem   <= w_num[DATA_W-1:0];
                                r_dq    <= '0;
                                r_quot  <= '0;
                                r_cnt   <= FRAC_CNT;
                                r_state <= S_DIV;
                            end
                        end else if (r_fi == w_last) begin
                            r_fres  <= r_y0;
                            r_state <= S_FRET;
                        end else begin
                            r_fxl  <= r_xrd;
                            r_fyl  <= r_yrd;
                            r_fi   <= r_fi + 1'b1;
                            r_addr <= r_fi + 1'b1;
                            r_wait <= 1'b1;
                        end
                    end
                    // shared restoring divider, one quotient bit per cycle
                    S_DIV: begin
                        r_rem  <= w_dge ? 32'(w_dt - {1'b0, r_dd}) : w_dt[DATA_W-1:0];
                        r_quot <= {r_quot[DATA_W-2:0], w_dge};
                        r_dq   <= {r_dq[DATA_W-2:0], 1'b0};
                        r_cnt  <= r_cnt - 1'b1;
                        if (r_cnt == 6'd1) begin
                            r_state <= S_FMUL;
                        end
                    end
                    S_FMUL: begin
                        r_prod  <= w_prod;
                        r_state <= S_FADD;
                    end
                    S_FADD: begin
                        r_fres  <= w_fsum[DATA_W-1:0];
                        r_state <= S_FRET;
                    end
                    // forward result: deliver or rate the sample
                    S_FRET: begin
                        if (!r_inv) begin
                            r_res   <= r_fres;
                            r_state <= S_OUT;
                        end else begin
                            if (!r_found || (w_err < r_best_err)) begin
                                r_found    <= 1'b1;
                                r_best_err <= w_err;
                                r_best_x   <= r_s[DATA_W-1:0];
                            end
                            if (w_snext < $signed({{2{r_sxr[DATA_W-1]}}, r_sxr})) begin
                                r_s     <= w_snext;
                                r_fv    <= w_snext[DATA_W-1:0];
                                r_state <= S_F0;
                            end else begin
                                r_state <= S_NXT;
                            end
                        end
                    end
                    // inverse search: next segment
                    S_SEG: begin
                        r_sxl   <= r_sxr;
                        r_syl   <= r_syr;
                        r_sxr   <= r_xrd;
                        r_syr   <= r_yrd;
                        r_state <= S_BR;
                    end
                    S_BR: begin
                        if (w_brk && (r_sxl < r_sxr)) begin
                            r_dq    <= w_diff[DATA_W-1:0];
                            r_state <= S_HDIV;
                        end else begin
                            r_state <= S_NXT;
                        end
                    end
                    // span divided by ten through the reciprocal
                    S_HDIV: begin
                        r_quot  <= DATA_W'(w_recip >> STEP_SHIFT);
                        r_state <= S_HSET;
                    end
                    S_HSET: begin
                        r_h     <= (r_quot < TENTH_Q) ? TENTH_Q : r_quot;
                        r_s     <= {{2{r_sxl[DATA_W-1]}}, r_sxl};
                        r_fv    <= r_sxl;
                        r_state <= S_F0;
                    end
                    S_NXT: begin
                        if (r_si == w_last) begin
                            r_res   <= r_best_x;
                            r_state <= S_OUT;
                        end else begin
                            r_si    <= r_si + 1'b1;
                            r_addr  <= r_si + 1'b1;
                            r_wait  <= 1'b1;
                            r_state <= S_SEG;
                        end
                    end
                    // hand the result to the output register
                    S_OUT: begin
                        if (!r_ovalid || !i_stall) begin
                            r_ovalid <= 1'b1;
                            r_ovalue <= r_res;
                            r_state  <= S_IDLE;
                        end
                    end
                    default: begin
                        r_state <= S_IDLE;
                    end
                endcase
            end
        end
    end

    // divider never runs with an exhausted count
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt != 6'd0))
        else $error("divider count exhausted");

    // a write transaction never produces a result
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == FUNC_WRITE && !r_ovalid) |=> !r_ovalid)
        else $error("write produced a result");

    // a new result only loads from the output state
    a_load_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_ovalid ##1 r_ovalid) |-> ($past(r_state) == S_OUT))
        else $error("result loaded outside output state");

endmodule
